// ===== hdl/bccp_pkg.sv =====
`timescale 1ns / 1ps

package bccp_pkg;

  // Field widths.
  localparam int CW  = 24;           // signed coordinate and push width
  localparam int SZW = CW - 1;       // box size and radius width
  localparam int GW  = CW + 3;       // doubled-scale geometry, signed
  localparam int AW  = CW;           // offset magnitude kept once it is in range
  localparam int SQW = 2 * AW + 1;   // squared distance

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // How an item is finished by the back end.
  typedef enum logic [1:0] {
    CLS_MISS,
    CLS_INSIDE,
    CLS_OUTSIDE
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic              sx;      // offset x is negative
    logic              sy;      // offset y is negative
    logic [AW-1:0]     ax;      // |offset x|, doubled scale
    logic [AW-1:0]     ay;      // |offset y|, doubled scale
    logic [SZW-1:0]    r;       // radius
    logic [SQW-1:0]    sq;      // squared distance, doubled scale
    logic [CW-1:0]     in_px;   // push when the centre is inside
    logic [CW-1:0]     in_py;
  } job_t;

endpackage

// ===== hdl/bccp_front.sv =====
`timescale 1ns / 1ps

module bccp_front import bccp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            adv_i,
  input  logic [CW-1:0]   bx_i,
  input  logic [CW-1:0]   by_i,
  input  logic [SZW-1:0]  w_i,
  input  logic [SZW-1:0]  h_i,
  input  logic [CW-1:0]   cx_i,
  input  logic [CW-1:0]   cy_i,
  input  logic [SZW-1:0]  r_i,
  output logic            push_o,
  output job_t            job_o
);

  typedef enum logic [1:0] {
    SIDE_L,
    SIDE_R,
    SIDE_B,
    SIDE_T
  } side_e;

  // Stage 1: box edges and doubled centre.
  logic                 v1_q, v2_q, v3_q;
  logic signed [GW-1:0] minx_q, maxx_q, miny_q, maxy_q, px_q, py_q;
  logic [SZW-1:0]       r1_q, r2_q, r3_q;
  logic signed [GW-1:0] bx_e, by_e, cx_e, cy_e, w_e, h_e;

  assign bx_e = {{(GW-CW){bx_i[CW-1]}}, bx_i};
  assign by_e = {{(GW-CW){by_i[CW-1]}}, by_i};
  assign cx_e = {{(GW-CW){cx_i[CW-1]}}, cx_i};
  assign cy_e = {{(GW-CW){cy_i[CW-1]}}, cy_i};
  assign w_e  = {{(GW-SZW){1'b0}}, w_i};
  assign h_e  = {{(GW-SZW){1'b0}}, h_i};

  // Stage 2: clamped offsets and the four side distances.
  logic signed [GW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [GW-1:0] dl_q, dr_q, db_q, dt_q;
  logic signed [GW-1:0] clx, cly;

  always_comb begin
    clx = (px_q < minx_q) ? minx_q : ((px_q > maxx_q) ? maxx_q : px_q);
    cly = (py_q < miny_q) ? miny_q : ((py_q > maxy_q) ? maxy_q : py_q);
    dx_d = px_q - clx;
    dy_d = py_q - cly;
  end

  // Stage 3: magnitudes, range check, squares and the nearest side.
  logic [GW-1:0]        absx, absy;
  logic [AW-1:0]        r2w;
  logic                 rng_d, rng_q, zero_q, sx_q, sy_q;
  logic [AW-1:0]        ax_q, ay_q;
  logic [2*AW-1:0]      sqx_q, sqy_q, r2sq_q;
  logic signed [GW-1:0] m_d;
  logic [GW-2:0]        m_q;
  side_e                side_d, side_q;

  always_comb begin
    absx  = dx_q[GW-1] ? GW'(-dx_q) : GW'(dx_q);
    absy  = dy_q[GW-1] ? GW'(-dy_q) : GW'(dy_q);
    r2w   = {r2_q, 1'b0};
    rng_d = (absx <= {{(GW-AW){1'b0}}, r2w}) && (absy <= {{(GW-AW){1'b0}}, r2w});
    m_d    = dl_q;
    side_d = SIDE_L;
    if (dr_q < m_d) begin
      m_d    = dr_q;
      side_d = SIDE_R;
    end
    if (db_q < m_d) begin
      m_d    = db_q;
      side_d = SIDE_B;
    end
    if (dt_q < m_d) begin
      m_d    = dt_q;
      side_d = SIDE_T;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      minx_q <= (bx_e <<< 1) - w_e;
      maxx_q <= (bx_e <<< 1) + w_e;
      miny_q <= (by_e <<< 1) - h_e;
      maxy_q <= (by_e <<< 1) + h_e;
      px_q   <= cx_e <<< 1;
      py_q   <= cy_e <<< 1;
      r1_q   <= r_i;

      dx_q <= dx_d;
      dy_q <= dy_d;
      dl_q <= px_q - minx_q;
      dr_q <= maxx_q - px_q;
      db_q <= py_q - miny_q;
      dt_q <= maxy_q - py_q;
      r2_q <= r1_q;

      rng_q  <= rng_d;
      zero_q <= (absx == '0) && (absy == '0);
      sx_q   <= dx_q[GW-1];
      sy_q   <= dy_q[GW-1];
      ax_q   <= absx[AW-1:0];
      ay_q   <= absy[AW-1:0];
      sqx_q  <= absx[AW-1:0] * absx[AW-1:0];
      sqy_q  <= absy[AW-1:0] * absy[AW-1:0];
      r2sq_q <= r2w * r2w;
      m_q    <= m_d[GW-2:0];
      side_q <= side_d;
      r3_q   <= r2_q;
    end
  end

  // Stage 4 (into the queue): hit test and the inside push.
  logic [SQW-1:0] sq;
  logic           hit;
  logic [GW-1:0]  lsum;
  logic [GW-2:0]  len;
  logic [CW-1:0]  pos, neg;

  always_comb begin
    sq   = {1'b0, sqx_q} + {1'b0, sqy_q};
    hit  = rng_q && (sq <= {1'b0, r2sq_q});
    lsum = {1'b0, m_q} + {{(GW-AW){1'b0}}, r3_q, 1'b0} + GW'(1);
    len  = lsum[GW-1:1];
    pos  = (len > {{(GW-1-CW){1'b0}}, CMAX}) ? CMAX : len[CW-1:0];
    neg  = (len > {{(GW-1-CW){1'b0}}, CMIN}) ? CMIN : CW'(-len[CW-1:0]);

    job_o       = '0;
    job_o.sx    = sx_q;
    job_o.sy    = sy_q;
    job_o.ax    = ax_q;
    job_o.ay    = ay_q;
    job_o.r     = r3_q;
    job_o.sq    = sq;
    if (!hit) begin
      job_o.cls = CLS_MISS;
    end else if (zero_q) begin
      job_o.cls = CLS_INSIDE;
    end else begin
      job_o.cls = CLS_OUTSIDE;
    end
    unique case (side_q)
      SIDE_L:  job_o.in_px = neg;
      SIDE_R:  job_o.in_px = pos;
      SIDE_B:  job_o.in_py = neg;
      SIDE_T:  job_o.in_py = pos;
      default: job_o.in_px = '0;
    endcase
  end

  assign push_o = v3_q && adv_i;

endmodule

// ===== hdl/bccp_queue.sv =====
`timescale 1ns / 1ps

module bccp_queue import bccp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  output logic  full_o,
  output logic  valid_o,
  output job_t  job_o
);

  localparam int DEPTH = 2;

  job_t       mem_q [DEPTH];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  // The back end never stalls, so any stored item leaves at once.
  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign job_o   = mem_q[rp_q];
  assign full_o  = (cnt_q == 2'(DEPTH));

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");

endmodule

// ===== hdl/bccp_back.sv =====
`timescale 1ns / 1ps

module bccp_back import bccp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  job_t           job_i,
  output logic           valid_o,
  output logic           hit_o,
  output logic [CW-1:0]  push_x_o,
  output logic [CW-1:0]  push_y_o
);

  localparam int NS = 5;    // normalize: shifts of 32, 16, 8, 4, 2 bits
  localparam int QS = 32;   // root bits
  localparam int DS = 26;   // quotient bits
  localparam int RW = 58;   // divider remainder

  typedef struct packed {
    job_t        job;
    logic [63:0] x;
    logic [4:0]  s;
  } nrm_t;

  typedef struct packed {
    job_t        job;
    logic [4:0]  s;
    logic [63:0] x;
    logic [63:0] res;
  } sqr_t;

  typedef struct packed {
    job_t          job;
    logic [31:0]   root;
    logic [RW-1:0] remx;
    logic [RW-1:0] remy;
    logic [DS-1:0] qx;
    logic [DS-1:0] qy;
  } div_t;

  function automatic nrm_t nrm_step(nrm_t a, int k);
    nrm_t        o;
    int          p;
    logic [63:0] msk;
    o   = a;
    p   = 16 >> k;
    msk = ~(64'hFFFF_FFFF_FFFF_FFFF >> (2 * p));
    if ((a.x & msk) == '0) begin
      o.x = a.x << (2 * p);
      o.s = a.s + 5'(p);
    end
    return o;
  endfunction

  function automatic sqr_t sqr_step(sqr_t a, int i);
    sqr_t        o;
    logic [63:0] b;
    o = a;
    b = 64'd1 << (62 - 2 * i);
    if (a.x >= a.res + b) begin
      o.x   = a.x - (a.res + b);
      o.res = (a.res >> 1) + b;
    end else begin
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t a, int i);
    div_t          o;
    logic [RW-1:0] d;
    int            b;
    o = a;
    b = DS - 1 - i;
    d = {{(RW-32){1'b0}}, a.root} << b;
    if (a.remx >= d) begin
      o.remx  = a.remx - d;
      o.qx[b] = 1'b1;
    end
    if (a.remy >= d) begin
      o.remy  = a.remy - d;
      o.qy[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [CW-1:0] mag(logic [DS-1:0] q, logic [AW-1:0] ad, logic ng);
    logic [DS:0]   t;
    logic [DS-1:0] m;
    logic [CW-1:0] v;
    t = {1'b0, q} - {{(DS+1-AW){1'b0}}, ad} + (DS+1)'(1);
    m = t[DS:1];
    v = (m > {{(DS-CW){1'b0}}, CMAX}) ? CMAX : m[CW-1:0];
    if (q < {{(DS-AW){1'b0}}, ad}) begin
      v = '0;
    end
    return ng ? CW'(-v) : v;
  endfunction

  logic [NS-1:0] n_vld_q;
  nrm_t          n_d [NS];
  nrm_t          n_q [NS];
  logic [QS-1:0] q_vld_q;
  sqr_t          q_d [QS];
  sqr_t          q_q [QS];
  logic          m_vld_q;
  div_t          m_d, m_q;
  logic [DS-1:0] d_vld_q;
  div_t          d_d [DS];
  div_t          d_q [DS];
  nrm_t          n_in;
  sqr_t          q_in;
  logic [31:0]   shx, shy;
  logic [54:0]   ax_r, ay_r;
  div_t          fin;
  logic          hit_d;
  logic [CW-1:0] px_d, py_d;
  cls_e          cls_q;

  always_comb begin
    n_in     = '0;
    n_in.job = job_i;
    n_in.x   = {{(64-SQW){1'b0}}, job_i.sq};
    n_d[0]   = nrm_step(n_in, 0);
    for (int k = 1; k < NS; k++) begin
      n_d[k] = nrm_step(n_q[k-1], k);
    end

    q_in     = '0;
    q_in.job = n_q[NS-1].job;
    q_in.s   = n_q[NS-1].s;
    q_in.x   = n_q[NS-1].x;
    q_d[0]   = sqr_step(q_in, 0);
    for (int i = 1; i < QS; i++) begin
      q_d[i] = sqr_step(q_q[i-1], i);
    end

    // Offsets scaled by the normalizing shift do not exceed the root.
    shx      = 32'({8'b0, q_q[QS-1].job.ax} << q_q[QS-1].s);
    shy      = 32'({8'b0, q_q[QS-1].job.ay} << q_q[QS-1].s);
    ax_r     = shx * q_q[QS-1].job.r;
    ay_r     = shy * q_q[QS-1].job.r;
    m_d      = '0;
    m_d.job  = q_q[QS-1].job;
    m_d.root = q_q[QS-1].res[31:0];
    m_d.remx = {{(RW-56){1'b0}}, ax_r, 1'b0};
    m_d.remy = {{(RW-56){1'b0}}, ay_r, 1'b0};

    d_d[0] = div_step(m_q, 0);
    for (int i = 1; i < DS; i++) begin
      d_d[i] = div_step(d_q[i-1], i);
    end

    fin = d_q[DS-1];
    unique case (fin.job.cls)
      CLS_INSIDE: begin
        hit_d = 1'b1;
        px_d  = fin.job.in_px;
        py_d  = fin.job.in_py;
      end
      CLS_OUTSIDE: begin
        hit_d = 1'b1;
        px_d  = mag(fin.qx, fin.job.ax, fin.job.sx);
        py_d  = mag(fin.qy, fin.job.ay, fin.job.sy);
      end
      default: begin
        hit_d = 1'b0;
        px_d  = '0;
        py_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= '0;
      q_vld_q <= '0;
      m_vld_q <= 1'b0;
      d_vld_q <= '0;
      valid_o <= 1'b0;
    end else begin
      n_vld_q <= {n_vld_q[NS-2:0], valid_i};
      q_vld_q <= {q_vld_q[QS-2:0], n_vld_q[NS-1]};
      m_vld_q <= q_vld_q[QS-1];
      d_vld_q <= {d_vld_q[DS-2:0], m_vld_q};
      valid_o <= d_vld_q[DS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    q_q      <= q_d;
    m_q      <= m_d;
    d_q      <= d_d;
    hit_o    <= hit_d;
    push_x_o <= px_d;
    push_y_o <= py_d;
    cls_q    <= fin.job.cls;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o && !hit_o |-> push_x_o == '0 && push_y_o == '0)
    else $error("miss with a nonzero push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o && cls_q == CLS_INSIDE |-> push_x_o == '0 || push_y_o == '0)
    else $error("inside push on both axes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> $past(d_vld_q[DS-1]))
    else $error("result without an item in the divider");

endmodule

// ===== hdl/box_circle_collision_push.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; the sqrt and divider are fully pipelined.
// The back end pops the queue whenever it holds an item, so it never holds more than one item and busy stays low.
// The receiver cannot stall: valid_o marks each result for exactly one cycle.
// Reset (rst_ni low, asynchronous) drops every item in flight; no result follows.

module box_circle_collision_push import bccp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [CW-1:0]   box_center_x_i,
  input  logic [CW-1:0]   box_center_y_i,
  input  logic [SZW-1:0]  box_width_i,
  input  logic [SZW-1:0]  box_height_i,
  input  logic [CW-1:0]   circle_center_x_i,
  input  logic [CW-1:0]   circle_center_y_i,
  input  logic [SZW-1:0]  circle_radius_i,
  output logic            valid_o,
  output logic            hit_o,
  output logic [CW-1:0]   push_x_o,
  output logic [CW-1:0]   push_y_o
);

  // The front end takes one item per cycle while the queue has room, works out
  // the box edges, the clamped offset, the squared distance and the nearest
  // side, and sorts the item into miss, inside or outside. Each classified item
  // enters a short queue; the back end pops it, normalizes the squared distance,
  // takes the square root one bit per stage and divides one quotient bit per
  // stage for both axes, then forms the final push.
  logic fifo_full;
  logic adv;
  logic push;
  job_t fjob;
  logic qvalid;
  job_t qjob;

  // The front pipeline moves only while the queue has room.
  assign adv  = !fifo_full;
  assign busy = !adv;

  bccp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .adv_i  (adv),
    .bx_i   (box_center_x_i),
    .by_i   (box_center_y_i),
    .w_i    (box_width_i),
    .h_i    (box_height_i),
    .cx_i   (circle_center_x_i),
    .cy_i   (circle_center_y_i),
    .r_i    (circle_radius_i),
    .push_o (push),
    .job_o  (fjob)
  );

  bccp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (fjob),
    .full_o (fifo_full),
    .valid_o(qvalid),
    .job_o  (qjob)
  );

  bccp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qvalid),
    .job_i   (qjob),
    .valid_o (valid_o),
    .hit_o   (hit_o),
    .push_x_o(push_x_o),
    .push_y_o(push_y_o)
  );

endmodule
